@@ sv/assert_macros.svh @@
// Assertion helpers for the vector accumulator checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ sv/v3acc_pkg.sv @@
package v3acc_pkg;
  localparam int WordBitsDef = 32;
  localparam int FracBitsDef = 16;
  localparam int OpBits = 3;
  localparam logic [OpBits-1:0] OP_LOAD  = 3'd0;
  localparam logic [OpBits-1:0] OP_ADD   = 3'd1;
  localparam logic [OpBits-1:0] OP_SUB   = 3'd2;
  localparam logic [OpBits-1:0] OP_SCALE = 3'd3;
  localparam logic [OpBits-1:0] OP_CROSS = 3'd4;
  localparam logic [OpBits-1:0] OP_LEN   = 3'd5;
  localparam logic [OpBits-1:0] OP_NORM  = 3'd6;

  // Handshake between sequencer and shared divide/root unit
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } iter_cmd_t;
endpackage

@@ sv/v3acc_iter.sv @@
// Shared iterative unit: restoring divide (one quotient bit a cycle) or
// digit-by-digit square root (one result bit a cycle).
module v3acc_iter import v3acc_pkg::*; #(
  parameter int N = 2 * WordBitsDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  iter_cmd_t     cmd,
  input  logic [N-1:0]  num,
  input  logic [N-1:0]  den,
  output logic          done,
  output logic [N-1:0]  res
);
  localparam int CB = $clog2(N + 1);
  logic [N-1:0]  q_r, q_nxt, n_r, n_nxt, d_r, d_nxt;
  logic [N:0]    rem_r, rem_nxt, trial;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, sq_r, sq_nxt, done_r, done_nxt;
  logic [N+1:0]  sq_t;

  always_comb begin
    q_nxt = q_r; n_nxt = n_r; d_nxt = d_r; rem_nxt = rem_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; sq_nxt = sq_r; done_nxt = 1'b0;
    trial = '0; sq_t = '0;
    if (cmd.start) begin
      busy_nxt = 1'b1; sq_nxt = cmd.is_sqrt; n_nxt = num; d_nxt = den;
      q_nxt = '0; rem_nxt = '0;
      cnt_nxt = cmd.is_sqrt ? CB'(N / 2) : CB'(N);
    end else if (busy_r) begin
      if (sq_r) begin
        // rem = rem*4 + next two bits; trial = 4q+1
        sq_t = {rem_r[N-1:0], n_r[N-1 -: 2]};
        if (sq_t >= {q_r, 2'b01}) begin
          rem_nxt = (N+1)'(sq_t - {q_r, 2'b01});
          q_nxt = {q_r[N-2:0], 1'b1};
        end else begin
          rem_nxt = (N+1)'(sq_t);
          q_nxt = {q_r[N-2:0], 1'b0};
        end
        n_nxt = {n_r[N-3:0], 2'b00};
      end else begin
        trial = {rem_r[N-1:0], n_r[N-1]};
        if (trial >= {1'b0, d_r}) begin
          rem_nxt = trial - {1'b0, d_r};
          q_nxt = {q_r[N-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt = {q_r[N-2:0], 1'b0};
        end
        n_nxt = {n_r[N-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CB'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0; sq_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt; sq_r <= sq_nxt;
    end
    q_r <= q_nxt; n_r <= n_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign res  = q_r;
endmodule

@@ sv/vec3_accumulator_alu.sv @@
// Channel | Beat fields (low bit up)                         | Handshake
// in_     | tdata: op, operand_x, operand_y, operand_z, scale | tvalid/tready
// out_    | tdata: result_x, result_y, result_z, magnitude    | tvalid/tready
//         | tuser: zero_length, overflowed                     |
// Load/add/sub/op 7 go from S_EXEC straight to S_OUT. Scale and cross run one
// product a cycle through the shared multiplier. Length with stale cache uses
// the bit-serial root. Normalize: root if the cache is stale, then, unless the
// length is zero, three 2*WORD_BITS-step divides on the shared divider.
// One beat in flight; in_tready is low from acceptance until the result is
// taken. Synchronous active-low reset clears accumulator and cache.
module vec3_accumulator_alu import v3acc_pkg::*; #(
  parameter int WORD_BITS = WordBitsDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // op, operand_x, operand_y, operand_z, scale_factor, zero pad
  input  logic [((OpBits + 4 * WORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // result_x, result_y, result_z, magnitude
  output logic [4 * WORD_BITS - 1:0] out_tdata,
  // zero_length, overflowed
  output logic [1:0] out_tuser
);
  localparam int W = WORD_BITS;
  localparam int P = 2 * W;
  localparam int E = 2 * W + 2;
  localparam logic signed [E-1:0] SMAX = E'((64'sd1 <<< (W - 1)) - 1);
  localparam logic signed [E-1:0] SMIN = -SMAX - E'(1);

  localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_SQ = 4'd2,
    S_ROOT = 4'd3, S_RWAIT = 4'd4, S_DIV = 4'd5, S_DWAIT = 4'd6,
    S_OUT = 4'd7, S_EXEC = 4'd8;

  logic [3:0] st_r, st_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [OpBits-1:0] op_r, op_nxt;
  logic signed [W-1:0] acc_r [3], acc_nxt [3], opd_r [3], opd_nxt [3];
  logic signed [W-1:0] sf_r, sf_nxt, newv_r [3], newv_nxt [3];
  logic [W-1:0] cm_r, cm_nxt, mag_r, mag_nxt;
  logic stale_r, stale_nxt, zl_r, zl_nxt, ov_r, ov_nxt, ovld_r, ovld_nxt;
  logic signed [P-1:0] prod_r, pa_r, pa_nxt;
  logic [P-1:0] sum_r, sum_nxt;
  logic signed [W-1:0] ma, mb;
  logic signed [E-1:0] ext, sv;
  logic [P-1:0] dnum;
  logic [P-1:0] ires;
  logic idone;
  iter_cmd_t icmd;
  logic [W-1:0] absc;
  logic [1:0] dsel;

  // Shared multiplier, registered product
  always_comb begin
    ma = '0; mb = '0;
    case (op_r)
      OP_SCALE: begin ma = acc_r[idx_r[1:0]]; mb = sf_r; end
      OP_CROSS: begin
        case (idx_r)
          3'd0: begin ma = acc_r[1]; mb = opd_r[2]; end
          3'd1: begin ma = acc_r[2]; mb = opd_r[1]; end
          3'd2: begin ma = acc_r[2]; mb = opd_r[0]; end
          3'd3: begin ma = acc_r[0]; mb = opd_r[2]; end
          3'd4: begin ma = acc_r[0]; mb = opd_r[1]; end
          default: begin ma = acc_r[1]; mb = opd_r[0]; end
        endcase
      end
      default: begin ma = acc_r[idx_r[1:0]]; mb = acc_r[idx_r[1:0]]; end
    endcase
  end
  always_ff @(posedge clk) prod_r <= ma * mb;

  v3acc_iter #(.N(P)) u_iter (
    .clk(clk), .rst_n(rst_n), .cmd(icmd), .num(dnum), .den(P'(mag_r)),
    .done(idone), .res(ires)
  );

  // divider numerator: while a divide finishes, present the next component
  assign dsel = (st_r == S_DWAIT && idx_r[1:0] != 2'd2) ? idx_r[1:0] + 2'd1 : idx_r[1:0];
  assign absc = acc_r[dsel][W-1] ? W'(-acc_r[dsel]) : acc_r[dsel];

  function automatic logic signed [E-1:0] satf(input logic signed [E-1:0] v,
                                               inout logic o);
    logic signed [E-1:0] r;
    r = v;
    if (v > SMAX) begin r = SMAX; o = 1'b1; end
    if (v < SMIN) begin r = SMIN; o = 1'b1; end
    return r;
  endfunction

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; op_nxt = op_r; sf_nxt = sf_r;
    cm_nxt = cm_r; mag_nxt = mag_r; stale_nxt = stale_r; zl_nxt = zl_r;
    ov_nxt = ov_r; ovld_nxt = ovld_r; pa_nxt = pa_r; sum_nxt = sum_r;
    icmd = '0; dnum = '0; ext = '0; sv = '0;
    for (int i = 0; i < 3; i++) begin
      acc_nxt[i] = acc_r[i]; opd_nxt[i] = opd_r[i]; newv_nxt[i] = newv_r[i];
    end
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_tdata[OpBits-1:0];
          for (int i = 0; i < 3; i++)
            opd_nxt[i] = in_tdata[OpBits + i*W +: W];
          sf_nxt = in_tdata[OpBits + 3*W +: W];
          idx_nxt = '0; zl_nxt = 1'b0; ov_nxt = 1'b0; mag_nxt = '0;
          sum_nxt = '0;
          st_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_LOAD: begin
            for (int i = 0; i < 3; i++) acc_nxt[i] = opd_r[i];
            stale_nxt = 1'b1; st_nxt = S_OUT;
          end
          OP_ADD, OP_SUB: begin
            for (int i = 0; i < 3; i++) begin
              if (op_r == OP_ADD) ext = E'(acc_r[i]) + E'(opd_r[i]);
              else ext = E'(acc_r[i]) - E'(opd_r[i]);
              sv = satf(ext, ov_nxt);
              acc_nxt[i] = sv[W-1:0];
            end
            stale_nxt = 1'b1; st_nxt = S_OUT;
          end
          OP_SCALE, OP_CROSS: st_nxt = S_MUL;
          OP_LEN, OP_NORM: begin
            if (stale_r) st_nxt = S_SQ;
            else begin
              mag_nxt = cm_r;
              st_nxt = (op_r == OP_NORM) ? S_DIV : S_OUT;
            end
          end
          default: st_nxt = S_OUT;
        endcase
      end
      // in S_MUL, prod_r holds the registered product of index idx_r-1
      S_MUL: begin
        idx_nxt = idx_r + 3'd1;
        if (idx_r != 3'd0) begin
          if (op_r == OP_SCALE) begin
            ext = E'(prod_r >>> FRAC_BITS);
            sv = satf(ext, ov_nxt);
            newv_nxt[2'(idx_r - 3'd1)] = sv[W-1:0];
          end else if (idx_r[0]) begin
            pa_nxt = prod_r;
          end else begin
            ext = E'(pa_r >>> FRAC_BITS) - E'(prod_r >>> FRAC_BITS)
                - ((P'(pa_r) & P'((64'd1 << FRAC_BITS) - 1))
                   < (P'(prod_r) & P'((64'd1 << FRAC_BITS) - 1)) ? E'(1) : E'(0));
            sv = satf(ext, ov_nxt);
            newv_nxt[2'(idx_r / 3'd2 - 3'd1)] = sv[W-1:0];
          end
        end
        if ((op_r == OP_SCALE && idx_r == 3'd3) || idx_r == 3'd6) begin
          for (int i = 0; i < 3; i++) acc_nxt[i] = newv_nxt[i];
          stale_nxt = 1'b1; st_nxt = S_OUT;
        end
      end
      // sum of squares, one square a cycle
      S_SQ: begin
        idx_nxt = idx_r + 3'd1;
        if (idx_r != 3'd0) sum_nxt = sum_r + P'(prod_r);
        if (idx_r == 3'd3) begin
          st_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        dnum = sum_r;
        icmd.start = 1'b1; icmd.is_sqrt = 1'b1; st_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        if (idone) begin
          mag_nxt = (ires > P'({W{1'b1}})) ? {W{1'b1}} : ires[W-1:0];
          cm_nxt = mag_nxt; stale_nxt = 1'b0;
          st_nxt = (op_r == OP_NORM) ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        idx_nxt = '0;
        if (mag_r == '0) begin
          zl_nxt = 1'b1; st_nxt = S_OUT;
        end else begin
          dnum = P'(absc) << FRAC_BITS;
          icmd.start = 1'b1; st_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        dnum = P'(absc) << FRAC_BITS;
        if (idone) begin
          ext = acc_r[idx_r[1:0]][W-1] ? -E'(ires) : E'(ires);
          sv = satf(ext, ov_nxt);
          newv_nxt[idx_r[1:0]] = sv[W-1:0];
          if (idx_r == 3'd2) begin
            for (int i = 0; i < 3; i++) acc_nxt[i] = newv_nxt[i];
            cm_nxt = ((64'd1 << FRAC_BITS) > 64'({W{1'b1}})) ? {W{1'b1}}
                   : W'(64'd1 << FRAC_BITS);
            stale_nxt = 1'b0; st_nxt = S_OUT;
          end else begin
            idx_nxt = idx_r + 3'd1; icmd.start = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (!ovld_r) begin ovld_nxt = 1'b1; end
        else if (out_tready) begin ovld_nxt = 1'b0; st_nxt = S_IDLE; end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Divider operand is sampled at start, so S_DWAIT must present the next
  // component's numerator; use the advancing index directly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; stale_r <= 1'b0; cm_r <= '0; ovld_r <= 1'b0; idx_r <= '0;
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
    end else begin
      st_r <= st_nxt; stale_r <= stale_nxt; cm_r <= cm_nxt; ovld_r <= ovld_nxt;
      idx_r <= idx_nxt;
      for (int i = 0; i < 3; i++) acc_r[i] <= acc_nxt[i];
    end
    op_r <= op_nxt; sf_r <= sf_nxt; mag_r <= mag_nxt; zl_r <= zl_nxt;
    ov_r <= ov_nxt; pa_r <= pa_nxt; sum_r <= sum_nxt;
    for (int i = 0; i < 3; i++) begin
      opd_r[i] <= opd_nxt[i]; newv_r[i] <= newv_nxt[i];
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = {mag_r, acc_r[2], acc_r[1], acc_r[0]};
  assign out_tuser  = {ov_r, zl_r};
endmodule

@@ sv/v3acc_checker.sv @@
`include "assert_macros.svh"
module v3acc_checker #(
  parameter int DW = 136,
  parameter int OW = 128
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [DW-1:0] in_tdata,
  input logic out_tvalid,
  input logic out_tready,
  input logic [OW-1:0] out_tdata,
  input logic [1:0] out_tuser
);
  // one item in flight: never ready while a result waits
  `CHK_IMPL(a_excl, clk, rst_n, out_tvalid, !in_tready, "ready with result pending")
  // accepted beat drops ready next cycle
  `CHK_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready && !out_tvalid,
            "still ready after accept")
  // stalled result holds
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready,
            out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result moved")
  // zero length flag comes with zero magnitude
  `CHK_IMPL(a_zl, clk, rst_n, out_tvalid && out_tuser[0],
            out_tdata[OW-1 -: OW/4] == '0, "zero_length with nonzero magnitude")
endmodule

bind vec3_accumulator_alu v3acc_checker #(
  .DW($bits(in_tdata)), .OW($bits(out_tdata))
) u_chk (.*);

@@ verif/vec3_accumulator_alu_test.sv @@
module vec3_accumulator_alu_test;
  import v3acc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam int IN_W = ((OpBits + 4 * WB + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [OpBits-1:0] OP_SPARE = 3'd7;

  typedef struct packed {
    logic [WB-1:0] rx;
    logic [WB-1:0] ry;
    logic [WB-1:0] rz;
    logic [WB-1:0] mag;
    logic          zl;
    logic          ov;
  } vec_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [4*WB-1:0] out_tdata;
  logic [1:0] out_tuser;

  // accumulator shadow
  longint sh_x, sh_y, sh_z;
  longint unsigned sh_len;
  bit sh_stale;

  vec_result_t pending_results[$];
  int err_count = 0;
  int beats_in = 0, beats_out = 0;
  int idle_cycles = 0;
  bit rx_hold = 1'b0;
  int rx_hold_cycles = 0;

  always #1 clk = ~clk;

  vec3_accumulator_alu DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  function automatic longint clamp32(longint v, ref bit ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // arithmetic shift is floor division by 2^FB
  function automatic longint qfloor(longint v);
    return v >>> FB;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned current_length();
    longint unsigned s, r;
    if (sh_stale) begin
      s = longint'(sh_x * sh_x) + longint'(sh_y * sh_y) + longint'(sh_z * sh_z);
      r = root64(s);
      sh_len = (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
      sh_stale = 1'b0;
    end
    return sh_len;
  endfunction

  function automatic longint div_by_len(longint c, longint unsigned len, ref bit ov);
    longint unsigned m, q;
    m = (c < 0) ? -c : c;
    q = (m << FB) / len;
    if (q > 64'd2147483648) q = 64'd2147483648;
    return clamp32((c < 0) ? -longint'(q) : longint'(q), ov);
  endfunction

  // cross terms: (a*b - c*d) floored; 64-bit-safe because products fit 63 bits
  function automatic longint cross_term(longint a, longint b, longint c, longint d);
    longint p = a * b;
    longint q = c * d;
    return qfloor(p) - qfloor(q) - ((p[FB-1:0] < q[FB-1:0]) ? 1 : 0);
  endfunction

  function automatic vec_result_t predict_step(logic [OpBits-1:0] op, logic signed [WB-1:0] ox,
      logic signed [WB-1:0] oy, logic signed [WB-1:0] oz, logic signed [WB-1:0] sf);
    vec_result_t r;
    bit ov = 1'b0;
    longint unsigned mag = 0;
    longint nx, ny, nz;
    r.zl = 1'b0;
    case (op)
      OP_LOAD: begin
        sh_x = ox; sh_y = oy; sh_z = oz; sh_stale = 1'b1;
      end
      OP_ADD: begin
        sh_x = clamp32(sh_x + ox, ov); sh_y = clamp32(sh_y + oy, ov);
        sh_z = clamp32(sh_z + oz, ov); sh_stale = 1'b1;
      end
      OP_SUB: begin
        sh_x = clamp32(sh_x - ox, ov); sh_y = clamp32(sh_y - oy, ov);
        sh_z = clamp32(sh_z - oz, ov); sh_stale = 1'b1;
      end
      OP_SCALE: begin
        sh_x = clamp32(qfloor(sh_x * sf), ov); sh_y = clamp32(qfloor(sh_y * sf), ov);
        sh_z = clamp32(qfloor(sh_z * sf), ov); sh_stale = 1'b1;
      end
      OP_CROSS: begin
        nx = clamp32(cross_term(sh_y, oz, sh_z, oy), ov);
        ny = clamp32(cross_term(sh_z, ox, sh_x, oz), ov);
        nz = clamp32(cross_term(sh_x, oy, sh_y, ox), ov);
        sh_x = nx; sh_y = ny; sh_z = nz; sh_stale = 1'b1;
      end
      OP_LEN: mag = current_length();
      OP_NORM: begin
        mag = current_length();
        if (mag == 0) begin
          r.zl = 1'b1;
        end else begin
          sh_x = div_by_len(sh_x, mag, ov);
          sh_y = div_by_len(sh_y, mag, ov);
          sh_z = div_by_len(sh_z, mag, ov);
          sh_len = 64'd1 << FB;
          sh_stale = 1'b0;
        end
      end
      default: ;
    endcase
    r.rx = sh_x[WB-1:0];
    r.ry = sh_y[WB-1:0];
    r.rz = sh_z[WB-1:0];
    r.mag = mag[WB-1:0];
    r.ov = ov;
    return r;
  endfunction

  // random gap: mostly short, occasionally long
  function automatic int pick_gap();
    int p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // valid stays high into the next beat when there is no gap
  task automatic send_beat(logic [OpBits-1:0] op, logic [WB-1:0] ox, logic [WB-1:0] oy,
      logic [WB-1:0] oz, logic [WB-1:0] sf);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_results.push_back(predict_step(op, ox, oy, oz, sf));
    in_tdata  <= {{(IN_W - OpBits - 4*WB){1'b0}}, sf, oz, oy, ox, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    beats_in++;
  endtask

  function automatic logic [WB-1:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(3 << FB) - (3 << FB) / 2;
      3: return $urandom_range(1 << 24) - (1 << 23);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    send_beat(OP_LEN, '0, '0, '0, '0);          // length of reset vector, cache valid
    send_beat(OP_NORM, '0, '0, '0, '0);         // zero vector normalise
    send_beat(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, '0);
    send_beat(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, '0);
    send_beat(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, '0);
    send_beat(OP_LEN, '0, '0, '0, '0);          // stale, fresh root of the saturated vector
    send_beat(OP_LEN, '0, '0, '0, '0);          // cached
    send_beat(OP_NORM, '0, '0, '0, '0);
    send_beat(OP_LEN, '0, '0, '0, '0);          // cache is 1.0
    send_beat(OP_LOAD, 32'h0003_0000, 32'hFFFC_0000, 32'h0000_0000, '0);
    send_beat(OP_SCALE, '0, '0, '0, 32'h8000_0000);
    send_beat(OP_SCALE, '0, '0, '0, 32'h7FFF_FFFF);
    send_beat(OP_LOAD, 32'h0001_8000, 32'hFFFF_4000, 32'h0002_0000, '0);
    send_beat(OP_SCALE, '0, '0, '0, 32'hFFFF_8001);
    send_beat(OP_CROSS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, '0);
    send_beat(OP_CROSS, 32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0007, '0);
    send_beat(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_LOAD, 32'h0000_0001, '0, '0, '0);
    send_beat(OP_NORM, '0, '0, '0, '0);         // tiny vector, quotient 1.0
    send_beat(OP_NORM, '0, '0, '0, '0);         // already unit
    wait_drained();
  endtask

  // a load (now and then op 7), then a random chain of up to five ops 0 to 6
  task automatic test_random_sequences(int n_beats);
    int sent = 0;
    logic [OpBits-1:0] op;
    while (sent < n_beats) begin
      if ($urandom_range(9) < 7) send_beat(OP_LOAD, rand_word(), rand_word(), rand_word(), '0);
      else send_beat(OP_SPARE, $urandom, $urandom, $urandom, $urandom);
      sent++;
      repeat ($urandom_range(5)) begin
        op = OpBits'($urandom_range(6));
        send_beat(op, rand_word(), rand_word(), rand_word(), rand_word());
        sent++;
      end
    end
  endtask

  // receiver stalls long while the sender keeps offering
  task automatic test_backpressure();
    rx_hold_cycles = 300;
    rx_hold = 1'b1;
    repeat (6) send_beat(OpBits'($urandom_range(7)), rand_word(), rand_word(), rand_word(),
                         rand_word());
    wait_drained();
  endtask

  // sender pauses until every result is back
  task automatic test_pause_and_drain();
    send_beat(OP_LOAD, rand_word(), rand_word(), rand_word(), '0);
    wait_drained();
    send_beat(OP_NORM, '0, '0, '0, '0);
    wait_drained();
  endtask

  // result side ready pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold) begin
      out_tready <= 1'b0;
      if (rx_hold_cycles > 0) rx_hold_cycles <= rx_hold_cycles - 1;
      else rx_hold <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(9) < 7);
    end
  end

  // result checker
  always @(posedge clk) begin
    vec_result_t exp_r, got;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      got = {out_tdata[WB-1:0], out_tdata[2*WB-1:WB], out_tdata[3*WB-1:2*WB],
             out_tdata[4*WB-1:3*WB], out_tuser[0], out_tuser[1]};
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.rx !== exp_r.rx) begin
          $error("result_x exp %h got %h", exp_r.rx, got.rx); err_count++;
        end
        if (got.ry !== exp_r.ry) begin
          $error("result_y exp %h got %h", exp_r.ry, got.ry); err_count++;
        end
        if (got.rz !== exp_r.rz) begin
          $error("result_z exp %h got %h", exp_r.rz, got.rz); err_count++;
        end
        if (got.mag !== exp_r.mag) begin
          $error("magnitude exp %h got %h", exp_r.mag, got.mag); err_count++;
        end
        if (got.zl !== exp_r.zl) begin
          $error("zero_length exp %b got %b", exp_r.zl, got.zl); err_count++;
        end
        if (got.ov !== exp_r.ov) begin
          $error("overflowed exp %b got %b", exp_r.ov, got.ov); err_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    sh_x = 0; sh_y = 0; sh_z = 0; sh_len = 0; sh_stale = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_backpressure();
    test_random_sequences(620);
    test_pause_and_drain();
    wait_drained();
    repeat (300) @(posedge clk);
    $display("Covered %0d beats in, %0d results: all ops, saturation, zero normalise,",
             beats_in, beats_out);
    $display("cached and fresh length, long receiver stall and drained pauses.");
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
